// ===== design/assert_macros.svh =====
// assertion macros used by the q24.8 alu top-level rtl
// no dependencies; define SYNTH to strip the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/q24a_pkg.sv =====
// package for the q24.8 fixed-point alu: widths, opcodes, error codes,
// shared structs and the saturation helpers; no dependencies
package q24a_pkg;

    localparam int DW         = 32;
    localparam int FB         = 8;
    localparam int OPW        = 4;
    localparam int MAGW       = 2 * DW + 1;
    localparam int DIV_BITS   = 4;
    localparam int QW         = DW + FB + 1;
    localparam int DIV_STAGES = (QW + DIV_BITS - 1) / DIV_BITS;
    localparam int NPW        = DIV_STAGES * DIV_BITS;
    localparam int RW         = DW + 1;
    localparam int MUL_LAT    = 2;
    localparam int MUL_DLY    = DIV_STAGES - MUL_LAT;

    localparam logic [OPW-1:0] OP_ADD    = 4'd0;
    localparam logic [OPW-1:0] OP_SUB    = 4'd1;
    localparam logic [OPW-1:0] OP_MUL    = 4'd2;
    localparam logic [OPW-1:0] OP_DIV    = 4'd3;
    localparam logic [OPW-1:0] OP_CMP    = 4'd4;
    localparam logic [OPW-1:0] OP_MIN    = 4'd5;
    localparam logic [OPW-1:0] OP_MAX    = 4'd6;
    localparam logic [OPW-1:0] OP_INC    = 4'd7;
    localparam logic [OPW-1:0] OP_DEC    = 4'd8;
    localparam logic [OPW-1:0] OP_FROM_I = 4'd9;
    localparam logic [OPW-1:0] OP_TO_I   = 4'd10;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_OVF  = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [MAGW-1:0] MAG_POS_LIM = {{(MAGW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [MAGW-1:0] MAG_NEG_LIM = MAG_POS_LIM + MAGW'(1);
    localparam logic [MAGW-1:0] HALF_M = MAGW'((1 << FB) >> 1);

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 ovf;
    } t_sat;

    typedef struct packed {
        logic lt;
        logic gt;
        logic eq;
    } t_flags;

    typedef struct packed {
        logic                 vld;
        logic [OPW-1:0]       op;
        logic signed [DW-1:0] val;
        logic [1:0]           err;
        t_flags               flags;
        logic                 div_neg;
    } t_side;

    // clamp a magnitude with a sign into the signed data range
    function automatic t_sat sat_mag(input logic [MAGW-1:0] mag, input logic neg);
        t_sat s;
        s.ovf = 1'b0;
        s.val = $signed(mag[DW-1:0]);
        if (neg) begin
            if (mag > MAG_NEG_LIM) begin
                s.val = VAL_MIN;
                s.ovf = 1'b1;
            end else begin
                s.val = $signed(-mag[DW-1:0]);
            end
        end else if (mag > MAG_POS_LIM) begin
            s.val = VAL_MAX;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    // clamp a one-bit-wider signed sum
    function automatic t_sat sat_wide(input logic signed [DW:0] v);
        t_sat s;
        s.ovf = v[DW] ^ v[DW-1];
        s.val = s.ovf ? (v[DW] ? VAL_MIN : VAL_MAX) : $signed(v[DW-1:0]);
        return s;
    endfunction

endpackage

// ===== design/q24a_mul.sv =====
// two-stage magnitude multiplier with round-half-away and saturation
// depends on q24a_pkg
module q24a_mul (
    input  logic                    i_clk,
    input  logic [q24a_pkg::DW-1:0] i_mag_a,
    input  logic [q24a_pkg::DW-1:0] i_mag_b,
    input  logic                    i_neg,
    output q24a_pkg::t_sat          o_res
);
    import q24a_pkg::*;

    logic [2*DW-1:0] r_prod;
    logic            r_neg;
    t_sat            r_res;
    logic [MAGW-1:0] rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_mag_a * i_mag_b;
        r_neg  <= i_neg;
    end

    // add half an lsb then drop the fraction bits
    assign rnd = (MAGW'(r_prod) + HALF_M) >> FB;

    always_ff @(posedge i_clk) begin
        r_res <= sat_mag(rnd, r_neg);
    end

    assign o_res = r_res;
endmodule

// ===== design/q24a_div.sv =====
// pipelined restoring divider, DIV_BITS quotient bits per stage
// depends on q24a_pkg
module q24a_div (
    input  logic                     i_clk,
    input  logic [q24a_pkg::NPW-1:0] i_num,
    input  logic [q24a_pkg::DW-1:0]  i_den,
    output logic [q24a_pkg::NPW-1:0] o_quo
);
    import q24a_pkg::*;

    logic [DW-1:0]  r_rem [DIV_STAGES];
    logic [DW-1:0]  r_den [DIV_STAGES];
    logic [NPW-1:0] r_num [DIV_STAGES];
    logic [NPW-1:0] r_quo [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DW-1:0]  in_rem, in_den, n_rem;
        logic [NPW-1:0] in_num, in_quo, n_num, n_quo;
        logic [RW-1:0]  t;

        if (s == 0) begin : g_first
            assign in_rem = '0;
            assign in_den = i_den;
            assign in_num = i_num;
            assign in_quo = '0;
        end else begin : g_next
            assign in_rem = r_rem[s-1];
            assign in_den = r_den[s-1];
            assign in_num = r_num[s-1];
            assign in_quo = r_quo[s-1];
        end

        always_comb begin
            n_rem = in_rem;
            n_num = in_num;
            n_quo = in_quo;
            t     = '0;
            for (int j = 0; j < DIV_BITS; j++) begin
                t     = {n_rem, n_num[NPW-1]};
                n_num = n_num << 1;
                if (t >= {1'b0, in_den}) begin
                    t     = t - {1'b0, in_den};
                    n_quo = {n_quo[NPW-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[NPW-2:0], 1'b0};
                end
                n_rem = t[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= in_den;
            r_num[s] <= n_num;
            r_quo[s] <= n_quo;
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
endmodule

// ===== design/q24_8_fixed_point_alu.sv =====
// an accepted word is registered in stage 1, stage 2, the side pipe that matches the divider
// and the output register, from which the receiver takes it
// throughput: one word per cycle, busy never rises; the divider pipe sets the depth
// reset: synchronous active-low i_rst_n clears every valid bit, results in flight drop
// results show for one cycle with o_valid; the receiver cannot stall
`include "assert_macros.svh"
module q24_8_fixed_point_alu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [q24a_pkg::OPW-1:0]       i_req_type,
    input  logic signed [q24a_pkg::DW-1:0] i_operand_a,
    input  logic signed [q24a_pkg::DW-1:0] i_operand_b,
    output logic                           o_valid,
    output logic signed [q24a_pkg::DW-1:0] o_result_value,
    output logic                           o_is_less,
    output logic                           o_is_greater,
    output logic                           o_is_equal,
    output logic [1:0]                     o_error_code
);
    import q24a_pkg::*;

    localparam int LAT = DIV_STAGES + 3;

    // stage 1: input capture
    logic                 r_s1_vld;
    logic [OPW-1:0]       r_s1_op;
    logic signed [DW-1:0] r_s1_a, r_s1_b;

    // fully pipelined, never back-pressures the sender
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op <= i_req_type;
        r_s1_a  <= i_operand_a;
        r_s1_b  <= i_operand_b;
    end

    // stage 2: simple ops, magnitudes and divider setup
    logic signed [DW:0]      sum_w, dif_w, inc_w, dec_w;
    logic signed [DW+FB-1:0] fi_w;
    logic [FB:0]             fi_hi;
    logic                    fi_ovf;
    t_sat                    s_sum, s_dif, s_inc, s_dec;
    t_side                   n_side;
    logic [DW-1:0]           n_ma, n_mb;
    logic                    a_lt_b, a_gt_b;

    assign sum_w  = (DW+1)'(r_s1_a) + (DW+1)'(r_s1_b);
    assign dif_w  = (DW+1)'(r_s1_a) - (DW+1)'(r_s1_b);
    assign inc_w  = (DW+1)'(r_s1_a) + (DW+1)'(1);
    assign dec_w  = (DW+1)'(r_s1_a) - (DW+1)'(1);
    assign s_sum  = sat_wide(sum_w);
    assign s_dif  = sat_wide(dif_w);
    assign s_inc  = sat_wide(inc_w);
    assign s_dec  = sat_wide(dec_w);
    // integer to fixed: shift up, overflow when the top bits are not a sign run
    assign fi_w   = (DW+FB)'(r_s1_a) <<< FB;
    assign fi_hi  = fi_w[DW+FB-1:DW-1];
    assign fi_ovf = (fi_hi != '0) && (fi_hi != '1);
    assign a_lt_b = r_s1_a < r_s1_b;
    assign a_gt_b = r_s1_a > r_s1_b;
    assign n_ma   = r_s1_a[DW-1] ? DW'(-r_s1_a) : DW'(r_s1_a);
    assign n_mb   = r_s1_b[DW-1] ? DW'(-r_s1_b) : DW'(r_s1_b);

    always_comb begin
        n_side         = '0;
        n_side.vld     = r_s1_vld;
        n_side.op      = r_s1_op;
        n_side.div_neg = r_s1_a[DW-1] ^ r_s1_b[DW-1];
        case (r_s1_op)
            OP_ADD: begin
                n_side.val = s_sum.val;
                n_side.err = s_sum.ovf ? ERR_OVF : ERR_NONE;
            end
            OP_SUB: begin
                n_side.val = s_dif.val;
                n_side.err = s_dif.ovf ? ERR_OVF : ERR_NONE;
            end
            OP_DIV: begin
                // divide by zero is settled here, the quotient is ignored
                n_side.err = (r_s1_b == '0) ? ERR_DIV0 : ERR_NONE;
            end
            OP_CMP: begin
                n_side.flags.lt = a_lt_b;
                n_side.flags.gt = a_gt_b;
                n_side.flags.eq = (r_s1_a == r_s1_b);
            end
            OP_MIN: n_side.val = a_lt_b ? r_s1_a : r_s1_b;
            OP_MAX: n_side.val = a_gt_b ? r_s1_a : r_s1_b;
            OP_INC: begin
                n_side.val = s_inc.val;
                n_side.err = s_inc.ovf ? ERR_OVF : ERR_NONE;
            end
            OP_DEC: begin
                n_side.val = s_dec.val;
                n_side.err = s_dec.ovf ? ERR_OVF : ERR_NONE;
            end
            OP_FROM_I: begin
                n_side.val = fi_ovf ? (r_s1_a[DW-1] ? VAL_MIN : VAL_MAX)
                                    : $signed(fi_w[DW-1:0]);
                n_side.err = fi_ovf ? ERR_OVF : ERR_NONE;
            end
            // arithmetic shift rounds toward minus infinity
            OP_TO_I: n_side.val = r_s1_a >>> FB;
            default: ;
        endcase
    end

    t_side          r_s2_side;
    logic [DW-1:0]  r_s2_ma, r_s2_mb;
    logic [NPW-1:0] r_s2_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.vld <= 1'b0;
        end else begin
            r_s2_side <= n_side;
        end
    end

    // divider gets 2*|a|*2^FB so the extra quotient bit gives the rounding
    always_ff @(posedge i_clk) begin
        r_s2_ma  <= n_ma;
        r_s2_mb  <= n_mb;
        r_s2_num <= NPW'(n_ma) << (FB + 1);
    end

    // multiplier and divider run side by side
    t_sat           mul_res;
    logic [NPW-1:0] div_quo;

    q24a_mul u_mul (
        .i_clk   (i_clk),
        .i_mag_a (r_s2_ma),
        .i_mag_b (r_s2_mb),
        .i_neg   (r_s2_side.div_neg),
        .o_res   (mul_res)
    );

    q24a_div u_div (
        .i_clk (i_clk),
        .i_num (r_s2_num),
        .i_den (r_s2_mb),
        .o_quo (div_quo)
    );

    // side info and the early multiply result wait for the divider
    t_side r_side    [DIV_STAGES];
    t_sat  r_mul_dly [MUL_DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_side[i].vld <= 1'b0;
            end
        end else begin
            r_side[0] <= r_s2_side;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_dly[0] <= mul_res;
        for (int i = 1; i < MUL_DLY; i++) begin
            r_mul_dly[i] <= r_mul_dly[i-1];
        end
    end

    // final stage: round quotient, select result
    t_side           side_end;
    t_sat            mul_end, div_sat;
    logic [MAGW-1:0] div_mag;
    logic signed [DW-1:0] n_val;
    logic [1:0]      n_err;

    assign side_end = r_side[DIV_STAGES-1];
    assign mul_end  = r_mul_dly[MUL_DLY-1];
    assign div_mag  = (MAGW'(div_quo) + MAGW'(1)) >> 1;
    assign div_sat  = sat_mag(div_mag, side_end.div_neg);

    always_comb begin
        n_val = side_end.val;
        n_err = side_end.err;
        case (side_end.op)
            OP_MUL: begin
                n_val = mul_end.val;
                n_err = mul_end.ovf ? ERR_OVF : ERR_NONE;
            end
            OP_DIV: begin
                if (side_end.err != ERR_DIV0) begin
                    n_val = div_sat.val;
                    n_err = div_sat.ovf ? ERR_OVF : ERR_NONE;
                end
            end
            default: ;
        endcase
    end

    logic                 r_out_vld;
    logic signed [DW-1:0] r_out_val;
    t_flags               r_out_flags;
    logic [1:0]           r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= side_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val   <= n_val;
        r_out_flags <= side_end.flags;
        r_out_err   <= n_err;
    end

    assign o_valid        = r_out_vld;
    assign o_result_value = r_out_val;
    assign o_is_less      = r_out_flags.lt;
    assign o_is_greater   = r_out_flags.gt;
    assign o_is_equal     = r_out_flags.eq;
    assign o_error_code   = r_out_err;

    // checks
    `ASSERT_IMPLY(a_lat, i_clk, i_rst_n, o_valid, $past(start && !busy, LAT), "result without a word accepted LAT cycles earlier")
    `ASSERT_IMPLY(a_err, i_clk, i_rst_n, o_valid, (o_error_code == ERR_NONE) || (o_error_code == ERR_OVF) || (o_error_code == ERR_DIV0), "bad error code")
    `ASSERT_IMPLY(a_flag, i_clk, i_rst_n, o_valid, $onehot0({o_is_less, o_is_greater, o_is_equal}), "more than one compare flag")
    `ASSERT_IMPLY(a_div0, i_clk, i_rst_n, o_valid && (o_error_code == ERR_DIV0), o_result_value == '0, "divide by zero with nonzero result")
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the q24.8 fixed-point alu
// depends on q24a_pkg and the q24_8_fixed_point_alu rtl
`timescale 1ns / 1ps
module tb_top;
    import q24a_pkg::*;

    localparam int LATENCY   = DIV_STAGES + 3;
    localparam int N_RANDOM  = 950;
    localparam int CYCLE_CAP = 200000;

    typedef struct {
        logic [OPW-1:0]       op;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
    } alu_word_t;

    typedef struct {
        logic signed [DW-1:0] val;
        logic                 lt;
        logic                 gt;
        logic                 eq;
        logic [1:0]           err;
    } alu_answer_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [OPW-1:0]       i_req_type;
    logic signed [DW-1:0] i_operand_a;
    logic signed [DW-1:0] i_operand_b;
    logic                 o_valid;
    logic signed [DW-1:0] o_result_value;
    logic                 o_is_less;
    logic                 o_is_greater;
    logic                 o_is_equal;
    logic [1:0]           o_error_code;

    q24_8_fixed_point_alu i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_is_less      (o_is_less),
        .o_is_greater   (o_is_greater),
        .o_is_equal     (o_is_equal),
        .o_error_code   (o_error_code)
    );

    alu_word_t   pending_words[$];
    alu_answer_t expected_answers[$];
    int          n_mismatch;
    int          cycle_count;
    bit          stimulus_done;
    bit          hold_for_drain;

    // clamp a wide signed value into the 32-bit range, flagging overflow
    function automatic void clamp32(input longint v, inout logic signed [DW-1:0] r,
                                    inout logic [1:0] err);
        if (v > 64'sd2147483647) begin
            r = VAL_MAX;
            err = ERR_OVF;
        end else if (v < -64'sd2147483648) begin
            r = VAL_MIN;
            err = ERR_OVF;
        end else begin
            r = v[DW-1:0];
        end
    endfunction

    // golden alu: one answer per word
    function automatic alu_answer_t alu_predict(input alu_word_t w);
        alu_answer_t     ans;
        longint          a, b, p, q;
        longint unsigned m, n, d;
        bit              neg;
        a = w.a;
        b = w.b;
        ans = '{val: '0, lt: 1'b0, gt: 1'b0, eq: 1'b0, err: ERR_NONE};
        case (w.op)
            OP_ADD: clamp32(a + b, ans.val, ans.err);
            OP_SUB: clamp32(a - b, ans.val, ans.err);
            OP_MUL: begin
                p = a * b;
                neg = p < 0;
                m = neg ? -p : p;
                m = (m + (1 << (FB - 1))) >> FB;
                q = m;
                clamp32(neg ? -q : q, ans.val, ans.err);
            end
            OP_DIV: begin
                if (b == 0) begin
                    ans.err = ERR_DIV0;
                end else begin
                    n = (a < 0 ? -a : a) << FB;
                    d = b < 0 ? -b : b;
                    q = (2 * n + d) / (2 * d);
                    clamp32(((a < 0) != (b < 0)) ? -q : q, ans.val, ans.err);
                end
            end
            OP_CMP: begin
                ans.lt = a < b;
                ans.gt = a > b;
                ans.eq = a == b;
            end
            OP_MIN: ans.val = (a < b) ? w.a : w.b;
            OP_MAX: ans.val = (a > b) ? w.a : w.b;
            OP_INC: clamp32(a + 1, ans.val, ans.err);
            OP_DEC: clamp32(a - 1, ans.val, ans.err);
            OP_FROM_I: clamp32(a * 256, ans.val, ans.err);
            OP_TO_I: ans.val = w.a >>> FB;
            default: ;
        endcase
        return ans;
    endfunction

    function automatic logic signed [DW-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return VAL_MAX - $urandom_range(0, 3);
            1: return VAL_MIN + $urandom_range(0, 3);
            2: return $signed(32'($urandom_range(0, 2048))) - 1024;
            3: return 0;
            4: return $signed(32'($urandom_range(0, 65535))) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input logic [OPW-1:0] op, input logic signed [DW-1:0] a,
                              input logic signed [DW-1:0] b);
        alu_word_t w;
        w.op = op;
        w.a = a;
        w.b = b;
        pending_words.push_back(w);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reset held low first, then stimulus
    initial begin
        alu_word_t w;
        i_rst_n = 1'b0;
        stimulus_done = 1'b0;
        hold_for_drain = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every opcode, saturation, divide by zero, rounding halves
        queue_word(OP_ADD, VAL_MAX, 32'sd1);
        queue_word(OP_ADD, VAL_MIN, -32'sd1);
        queue_word(OP_SUB, VAL_MIN, 32'sd1);
        queue_word(OP_SUB, VAL_MAX, VAL_MIN);
        queue_word(OP_MUL, 32'sd384, 32'sd128);     // 1.5 * 0.5 = 0.75, exact, no rounding
        queue_word(OP_MUL, -32'sd384, 32'sd128);    // -1.5 * 0.5 = -0.75, exact, no rounding
        queue_word(OP_MUL, VAL_MAX, VAL_MAX);
        queue_word(OP_MUL, VAL_MIN, VAL_MIN);
        queue_word(OP_MUL, VAL_MIN, 32'sd256);
        queue_word(OP_DIV, 32'sd256, 32'sd0);
        queue_word(OP_DIV, 32'sd256, 32'sd512);
        queue_word(OP_DIV, -32'sd1, 32'sd512);
        queue_word(OP_DIV, VAL_MIN, 32'sd1);
        queue_word(OP_DIV, VAL_MIN, -32'sd256);
        queue_word(OP_CMP, 32'sd5, 32'sd5);
        queue_word(OP_CMP, VAL_MIN, VAL_MAX);
        queue_word(OP_CMP, VAL_MAX, VAL_MIN);
        queue_word(OP_MIN, -32'sd3, 32'sd7);
        queue_word(OP_MAX, -32'sd3, 32'sd7);
        queue_word(OP_INC, VAL_MAX, 32'sd0);
        queue_word(OP_DEC, VAL_MIN, 32'sd0);
        queue_word(OP_FROM_I, 32'sd8388608, 32'sd0);
        queue_word(OP_FROM_I, -32'sd8388609, 32'sd0);
        queue_word(OP_TO_I, -32'sd1, 32'sd0);
        queue_word(4'd15, VAL_MAX, VAL_MIN);        // unknown opcode gives all zeros

        // pause until everything in flight has come back
        wait (pending_words.size() == 0);
        hold_for_drain = 1'b1;
        // the last word on the ports is taken at the next edge
        @(posedge i_clk);
        #1;
        wait (expected_answers.size() == 0);
        @(posedge i_clk);
        hold_for_drain <= 1'b0;

        // random words: mostly legal opcodes, a few unknown ones
        for (int k = 0; k < N_RANDOM; k++) begin
            w.op = ($urandom_range(0, 19) == 0) ? OPW'($urandom_range(11, 15))
                                                : OPW'($urandom_range(0, 10));
            w.a = rand_operand();
            w.b = rand_operand();
            pending_words.push_back(w);
        end
        wait (pending_words.size() == 0);
        stimulus_done = 1'b1;
    end

    // driver: bursts of back-to-back words separated by random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        alu_word_t w;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req_type <= '0;
            i_operand_a <= '0;
            i_operand_b <= '0;
            burst_left <= $urandom_range(1, 20);
            gap_left <= 0;
        end else begin
            // the word on the ports is taken at this edge when busy is low
            if (!(start && busy)) begin
                if (gap_left > 0 || hold_for_drain || pending_words.size() == 0) begin
                    start <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    w = pending_words.pop_front();
                    start <= 1'b1;
                    i_req_type <= w.op;
                    i_operand_a <= w.a;
                    i_operand_b <= w.b;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // monitor: predict at acceptance, compare every strobed result
    always @(posedge i_clk) begin
        alu_word_t   w;
        alu_answer_t e;
        if (i_rst_n) begin
            if (start && !busy) begin
                w.op = i_req_type;
                w.a = i_operand_a;
                w.b = i_operand_b;
                expected_answers.push_back(alu_predict(w));
            end
            if (o_valid) begin
                if (expected_answers.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result word: value %0d", o_result_value);
                end else begin
                    e = expected_answers.pop_front();
                    if (o_result_value !== e.val || o_is_less !== e.lt
                        || o_is_greater !== e.gt || o_is_equal !== e.eq
                        || o_error_code !== e.err) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("bad word: exp val %0d lt%b gt%b eq%b err%0d, got %0d lt%b gt%b eq%b err%0d",
                                     e.val, e.lt, e.gt, e.eq, e.err, o_result_value,
                                     o_is_less, o_is_greater, o_is_equal, o_error_code);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("q24_8_fixed_point_alu: mismatch");
            $finish;
        end
    end

    // end of run: drain, let trailing strobes show, then report
    initial begin
        n_mismatch = 0;
        cycle_count = 0;
        wait (stimulus_done);
        wait (expected_answers.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_mismatch == 0 && expected_answers.size() == 0)
            $display("q24_8_fixed_point_alu: match");
        else
            $display("q24_8_fixed_point_alu: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/q24a_pkg.sv
design/q24a_mul.sv
design/q24a_div.sv
design/q24_8_fixed_point_alu.sv
sim/tb_top.sv
